// ===== sv/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit policy block allocator
// Request and response payloads, policy and mode codes, register indexes,
// sequencer states and the control group of the pick unit.
// ----------------------------------------------------------------------------
package fpba_pkg;

   // Default sizing of the block table
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // Fixed field widths of the ports
   localparam int SLOT_W    = 4;
   localparam int AMOUNT_W  = 16;
   localparam int POLICY_W  = 2;
   localparam int ACTIVE_W  = 5;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 5;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_BLOCKS = CSR_IDX_W'(1);

   // Reset values of the configuration registers
   localparam logic [POLICY_W-1:0] FIT_POLICY_RST    = '0;
   localparam logic [ACTIVE_W-1:0] ACTIVE_BLOCKS_RST = ACTIVE_W'(16);

   // Request kinds
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   // Placement rules; the unused code behaves as first fit
   typedef enum logic [POLICY_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_policy_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                mode;
      logic [SLOT_W-1:0]   block_slot;
      logic [AMOUNT_W-1:0] amount;
      logic                last_request;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [SLOT_W-1:0]   chosen_block;
      logic [AMOUNT_W-1:0] remaining;
      logic                batch_end;
   } rsp_type;

   // Control of the pick unit
   typedef struct packed {
      logic clear;
      logic sample;
   } pick_ctl_type;

endpackage

// ===== sv/fpba_ram.sv =====
// ----------------------------------------------------------------------------
// fpba_ram: generic single write, single read RAM
// One write port and one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fpba_pick_unit.sv =====
// ----------------------------------------------------------------------------
// fpba_pick_unit: running selection of the fitting block
// Compares one table entry a cycle against the request and the best block
// seen so far, and keeps the chosen index and its free size.
// ----------------------------------------------------------------------------
module fpba_pick_unit #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fpba_pkg::pick_ctl_type            ctl,
   input  logic [fpba_pkg::POLICY_W-1:0]     policy,
   input  logic [SIZE_BITS-1:0]              amount,
   input  logic [SIZE_BITS-1:0]              data,
   input  logic [IDX_W-1:0]                  index,
   output logic                              found,
   output logic [IDX_W-1:0]                  pick,
   output logic [SIZE_BITS-1:0]              best
);

   import fpba_pkg::*;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic                 fits;
   logic                 better;

   // Decide whether the sampled entry replaces the current choice
   always_comb begin
      fits = (data >= amount);
      if (!found_ff) begin
         better = 1'b1;
      end else if (policy == FIT_BEST) begin
         better = (data < best_ff);
      end else if (policy == FIT_WORST) begin
         better = (data > best_ff);
      end else begin
         better = 1'b0;
      end

      found_in = found_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      priority if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && fits && better) begin
         found_in = 1'b1;
         pick_in  = index;
         best_in  = data;
      end else begin
         // hold the current choice
         found_in = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_ff <= pick_in;
      best_ff <= best_in;
   end

   assign found = found_ff;
   assign pick  = pick_ff;
   assign best  = best_ff;

endmodule

// ===== sv/fit_policy_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top: first, best and worst fit block allocator
// A load request writes one block's free size and gives no response. An
// allocation request scans blocks 0 to L-1, where L is active_blocks capped
// at MAX_BLOCKS, one table entry per cycle through the single read port of
// the table, then writes the chosen block back if one fits. busy stays high
// through the scan and write back states, so a new request is taken only
// once the block is idle again; the response is registered from the write
// back state. rsp_valid is high for exactly one cycle per allocation and the
// receiver cannot stall it. The table has no reset; only loaded blocks may
// be scanned.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top #(
   parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  fpba_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   output fpba_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [fpba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpba_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   import fpba_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int LIM_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

   state_type             state_ff, state_in;
   logic [POLICY_W-1:0]   fit_policy_ff, fit_policy_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic [POLICY_W-1:0]   policy_ff, policy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [SIZE_BITS-1:0]  amt_ff, amt_in;
   logic                  last_ff, last_in;
   logic                  vld_ff, vld_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  issue;
   logic [LIM_W-1:0]      act_ext;
   logic                  slot_ok;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [SIZE_BITS-1:0]  ram_wdata;
   logic [SIZE_BITS-1:0]  ram_rdata;
   logic [SIZE_BITS-1:0]  diff;
   pick_ctl_type          pick_ctl;
   logic                  found;
   logic [IDX_W-1:0]      pick;
   logic [SIZE_BITS-1:0]  best;

   assign accept  = start && !busy;
   assign act_ext = LIM_W'(active_ff);
   assign slot_ok = (int'(req_data.block_slot) < MAX_BLOCKS);
   assign issue   = (cnt_ff != limit_ff);
   assign diff    = best - amt_ff;

   // Capture configuration writes
   always_comb begin
      fit_policy_in = fit_policy_ff;
      active_in     = active_ff;
      if (csr_we && (csr_index == CSR_FIT_POLICY)) begin
         fit_policy_in = csr_wdata[POLICY_W-1:0];
      end
      if (csr_we && (csr_index == CSR_ACTIVE_BLOCKS)) begin
         active_in = csr_wdata[ACTIVE_W-1:0];
      end
   end

   // Sequence load, scan and write back
   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      amt_in       = amt_ff;
      last_in      = last_ff;
      vld_in       = 1'b0;
      idx_in       = cnt_ff[IDX_W-1:0];
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pick_ctl     = '{clear: 1'b0, sample: vld_ff};
      ram_we       = 1'b0;
      ram_waddr    = pick;
      ram_wdata    = diff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.mode == MODE_LOAD)) begin
               ram_we    = slot_ok;
               ram_waddr = IDX_W'(req_data.block_slot);
               ram_wdata = SIZE_BITS'(req_data.amount);
            end else if (accept) begin
               policy_in      = fit_policy_ff;
               amt_in         = SIZE_BITS'(req_data.amount);
               last_in        = req_data.last_request;
               cnt_in         = '0;
               limit_in       = (act_ext > LIM_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : CNT_W'(act_ext);
               pick_ctl.clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle; the previous read is compared meanwhile
            if (issue) begin
               vld_in = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we                = found;
            rsp_valid_in          = 1'b1;
            rsp_in.granted        = found;
            rsp_in.chosen_block   = found ? SLOT_W'(pick) : '0;
            rsp_in.remaining      = found ? AMOUNT_W'(diff) : '0;
            rsp_in.batch_end      = last_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fit_policy_ff <= FIT_POLICY_RST;
         active_ff     <= ACTIVE_BLOCKS_RST;
         vld_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         limit_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         fit_policy_ff <= fit_policy_in;
         active_ff     <= active_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         limit_ff      <= limit_in;
      end
      policy_ff <= policy_in;
      amt_ff    <= amt_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   fpba_pick_unit #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W)
   ) u_pick (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pick_ctl),
      .policy (policy_ff),
      .amount (amt_ff),
      .data   (ram_rdata),
      .index  (idx_ff),
      .found  (found),
      .pick   (pick),
      .best   (best)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A response follows only the write back step
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WRITE))
      else $error("response without write back");

   // The scan counter never passes the scan limit
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= limit_ff))
      else $error("scan counter beyond limit");

   // A granted block lies inside the scanned range
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && found) |-> (CNT_W'(pick) < limit_ff))
      else $error("chosen block outside scanned range");
`endif

endmodule

// ===== test/fit_policy_block_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_checker: response predictor and scoreboard
// Watches the request, response and register ports of the allocator. Keeps
// its own copy of the free-size table, the placement rule and the active
// block count, works out the response of every accepted allocation request
// and compares each observed response with the oldest expected one.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  fpba_pkg::req_type                  req_data,
   input  logic                               rsp_valid,
   input  fpba_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [fpba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpba_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_count,
   output int                                 grant_count,
   output int                                 deny_count
);
   import fpba_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [AMOUNT_W-1:0] block_free [MAX_BLOCKS_DEF];
   logic [POLICY_W-1:0] placement;
   logic [ACTIVE_W-1:0] scan_count;
   rsp_type             expected_q [$];
   int                  mismatches = 0;
   int                  grants     = 0;
   int                  denials    = 0;

   // Pick a block for one allocation request and take the amount from it
   function automatic rsp_type allocate(input req_type item);
      rsp_type outcome;
      int      limit;
      int      pick;
      bit      found;
      limit = (scan_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(scan_count);
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < limit; j++) begin
         if (block_free[j] >= item.amount) begin
            if (!found) begin
               found = 1'b1;
               pick  = j;
               // first fit, and the unused code, stop at the first hit
               if (placement != FIT_BEST && placement != FIT_WORST) break;
            end else if (placement == FIT_BEST && block_free[j] < block_free[pick]) begin
               pick = j;
            end else if (placement == FIT_WORST && block_free[j] > block_free[pick]) begin
               pick = j;
            end
         end
      end
      outcome           = '0;
      outcome.batch_end = item.last_request;
      if (found) begin
         block_free[pick]     = block_free[pick] - item.amount;
         outcome.granted      = 1'b1;
         outcome.chosen_block = SLOT_W'(pick);
         outcome.remaining    = block_free[pick];
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         placement  = FIT_POLICY_RST;
         scan_count = ACTIVE_BLOCKS_RST;
         expected_q.delete();
         for (int j = 0; j < MAX_BLOCKS_DEF; j++) block_free[j] = '0;
      end else begin
         // compare the response first, then take in a new request
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response with none outstanding: granted=%0d block=%0d",
                           $time, rsp_data.granted, rsp_data.chosen_block);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.granted !== want.granted ||
                   rsp_data.chosen_block !== want.chosen_block ||
                   rsp_data.remaining !== want.remaining ||
                   rsp_data.batch_end !== want.batch_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: response mismatch", $time);
                     $display("   expected granted=%0d block=%0d remaining=%0d batch_end=%0d",
                              want.granted, want.chosen_block, want.remaining,
                              want.batch_end);
                     $display("   actual   granted=%0d block=%0d remaining=%0d batch_end=%0d",
                              rsp_data.granted, rsp_data.chosen_block, rsp_data.remaining,
                              rsp_data.batch_end);
                  end
               end
            end
         end

         if (start && !busy) begin
            if (req_data.mode == MODE_LOAD) begin
               block_free[req_data.block_slot] = req_data.amount;
            end else begin
               want = allocate(req_data);
               if (want.granted) grants++;
               else denials++;
               expected_q.push_back(want);
            end
         end

         // mirror register writes; other indexes do nothing
         if (csr_we) begin
            if (csr_index == CSR_FIT_POLICY) placement = csr_wdata[POLICY_W-1:0];
            else if (csr_index == CSR_ACTIVE_BLOCKS) scan_count = csr_wdata;
         end
      end

      mismatch_count <= mismatches;
      pending_count  <= expected_q.size();
      grant_count    <= grants;
      deny_count     <= denials;
   end

endmodule

// ===== test/fit_policy_block_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top_test: allocator testbench top
// Drives load and allocation requests and register writes into the block,
// with a directed opening and then random batches under a range of placement
// rules and active block counts. A checker beside the block predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top_test;
   import fpba_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int SEGMENTS      = 9;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int grant_count;
   int deny_count;
   int cycle_count     = 0;
   int sender_idle_pct = 0;
   int load_count      = 0;
   int alloc_count     = 0;
   int setting_count   = 0;

   fit_policy_block_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fit_policy_block_allocator_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .grant_count    (grant_count),
      .deny_count     (deny_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("FAIL");
         $finish;
      end
   end

   // Send one request; start stays high when the next one follows at once
   task automatic issue(input logic mode, input logic [SLOT_W-1:0] slot,
                        input logic [AMOUNT_W-1:0] amount, input logic last);
      req_type item;
      item.mode         = mode;
      item.block_slot   = slot;
      item.amount       = amount;
      item.last_request = last;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode == MODE_LOAD) load_count++;
      else alloc_count++;
   endtask

   // Hold off until every expected response is in and the block is quiet
   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_FIT_POLICY || index == CSR_ACTIVE_BLOCKS) setting_count++;
   endtask

   // Size or amount: mostly small, with zeros, full scale and random values
   function automatic logic [AMOUNT_W-1:0] pick_amount(input int small_max);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      if (roll < 40) return AMOUNT_W'($urandom);
      return AMOUNT_W'($urandom_range(0, small_max));
   endfunction

   initial begin
      logic [AMOUNT_W-1:0] size;
      logic [CSR_DAT_W-1:0] active;
      logic                 last;
      int                   seg_len;
      int                   issued;
      int                   reloads;
      int                   batch;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every block before any scan; blocks 2 and 9 tie at 500
      sender_idle_pct = 37;
      for (int j = 0; j < MAX_BLOCKS_DEF; j++) begin
         case (j)
            0:       size = '0;
            1:       size = '1;
            9:       size = AMOUNT_W'(500);
            14:      size = 16'hAAAA;
            15:      size = 16'h5555;
            default: size = AMOUNT_W'(j * 250);
         endcase
         issue(MODE_LOAD, SLOT_W'(j), size, 1'b0);
      end

      // First fit at reset settings: zero request, then the full range
      issue(MODE_ALLOC, 4'hF, '0, 1'b0);
      issue(MODE_ALLOC, 4'h0, '1, 1'b1);
      settle();
      write_csr(CSR_FIT_POLICY, CSR_DAT_W'(FIT_BEST));
      issue(MODE_ALLOC, 4'h5, AMOUNT_W'(400), 1'b1);
      settle();
      write_csr(CSR_FIT_POLICY, CSR_DAT_W'(FIT_WORST));
      issue(MODE_ALLOC, 4'hA, AMOUNT_W'(1), 1'b0);
      issue(MODE_ALLOC, 4'h3, '1, 1'b1);
      settle();
      // unused policy code, upper data bits set
      write_csr(CSR_FIT_POLICY, 5'b11111);
      issue(MODE_ALLOC, 4'hC, AMOUNT_W'(300), 1'b1);
      settle();
      // no active blocks: nothing is granted
      write_csr(CSR_ACTIVE_BLOCKS, '0);
      issue(MODE_ALLOC, 4'h0, '0, 1'b1);
      settle();
      // active count beyond the table is capped
      write_csr(CSR_ACTIVE_BLOCKS, '1);
      issue(MODE_ALLOC, 4'h6, AMOUNT_W'(7), 1'b0);
      settle();
      // unknown register indexes change nothing
      write_csr(CSR_ACTIVE_BLOCKS, CSR_DAT_W'(1));
      write_csr('1, 5'b10101);
      write_csr(CSR_IDX_W'($urandom_range(2, 14)), CSR_DAT_W'($urandom));
      issue(MODE_ALLOC, 4'h9, '0, 1'b0);
      issue(MODE_ALLOC, 4'h9, AMOUNT_W'(1), 1'b1);

      // Random batches: now and then one to four reloads, then one to six allocations
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         sender_idle_pct = (seg < 3) ? 37 : (seg < 6) ? 73 : 0;
         case (seg)
            1, 6:    active = CSR_DAT_W'($urandom_range(2, 15));
            3:       active = CSR_DAT_W'(1);
            4:       active = CSR_DAT_W'($urandom_range(17, 31));
            7:       active = '0;
            default: active = CSR_DAT_W'(16);
         endcase
         write_csr(CSR_FIT_POLICY, {3'($urandom), 2'(seg % 4)});
         write_csr(CSR_ACTIVE_BLOCKS, active);
         seg_len = (seg == 7) ? 40 : 165;
         issued  = 0;
         while (issued < seg_len) begin
            if ($urandom_range(0, 99) < 35) begin
               reloads = $urandom_range(1, 4);
               repeat (reloads) issue(MODE_LOAD, SLOT_W'($urandom), pick_amount(3000),
                                      1'($urandom));
               issued += reloads;
            end
            batch = $urandom_range(1, 6);
            for (int k = 0; k < batch; k++) begin
               last = (k == batch - 1);
               // now and then mark the batch end in the wrong place
               if ($urandom_range(0, 99) < 8) last = ~last;
               issue(MODE_ALLOC, SLOT_W'($urandom), pick_amount(600), last);
            end
            issued += batch;
         end
      end

      settle();
      $display("covered %0d loads and %0d allocations over %0d register writes",
               load_count, alloc_count, setting_count);
      $display("all placement codes, active counts 0 to 31: %0d granted, %0d refused",
               grant_count, deny_count);
      if (pending_count != 0)
         $display("%0d expected responses never arrived", pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fpba_pick_unit.sv
sv/fit_policy_block_allocator_top.sv
test/fit_policy_block_allocator_checker.sv
test/fit_policy_block_allocator_top_test.sv
